>>> sv/rtnv_pkg.sv
// Package for the RGB to NV21 converter: payload structs, dimension limits
// and BT.601 coefficients. No dependencies.
package rtnv_pkg;

    localparam int MAX_DIM       = 4096;
    localparam int DIM_W         = 13;
    localparam int CNT_W         = 12;
    localparam int LUMA_IDX_W    = 24;
    localparam int CHROMA_IDX_W  = 23;
    localparam int PADDR_W       = 3;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [DIM_W-1:0] DIM_MAX      = DIM_W'(MAX_DIM);

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // coefficients, 16-bit arithmetic wraps exactly since results fit
    localparam logic [15:0] C_Y_R  = 16'd66;
    localparam logic [15:0] C_Y_G  = 16'd129;
    localparam logic [15:0] C_Y_B  = 16'd25;
    localparam logic [15:0] C_U_R  = 16'd38;
    localparam logic [15:0] C_U_G  = 16'd74;
    localparam logic [15:0] C_UV_M = 16'd112;
    localparam logic [15:0] C_V_G  = 16'd94;
    localparam logic [15:0] C_V_B  = 16'd18;
    localparam logic [15:0] C_RND  = 16'd128;
    localparam logic [15:0] C_BIAS = 16'd32896;   // 128 rounding + 128*256 offset
    localparam logic [7:0]  Y_OFS  = 8'd16;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0]              luma;
        logic [LUMA_IDX_W-1:0]   luma_index;
        logic                    chroma_valid;
        logic [7:0]              chroma;
        logic                    chroma_is_cb;
        logic [CHROMA_IDX_W-1:0] chroma_index;
        logic                    frame_last;
    } t_result;

    // classified pixel handed from front to back
    typedef struct packed {
        t_pixel                  pixel;
        logic [LUMA_IDX_W-1:0]   luma_index;
        logic                    chroma_valid;
        logic                    chroma_is_cb;
        logic [CHROMA_IDX_W-1:0] chroma_index;
        logic                    frame_last;
    } t_task;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_dims;

endpackage

>>> sv/rtnv_front.sv
// Front end: tracks frame position and plane offsets, tags each pixel.
// Depends on rtnv_pkg.
module rtnv_front import rtnv_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_dims  i_dims,
    input  logic   i_accept,
    input  t_pixel i_pixel,
    output t_task  o_task
);

    logic [CNT_W-1:0]        r_col, n_col;
    logic [CNT_W-1:0]        r_row, n_row;
    logic [LUMA_IDX_W-1:0]   r_luma_ptr;
    logic [CHROMA_IDX_W-1:0] r_cr_ptr, r_cb_ptr;
    logic [DIM_W-1:0]        w, h;
    logic                    last_col, last_row, frame_end, cvalid, odd_row;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (v > DIM_MAX) begin
            return DIM_MAX;
        end
        return v;
    endfunction

    always_comb begin
        w         = clamp_dim(i_dims.width);
        h         = clamp_dim(i_dims.height);
        last_col  = ({1'b0, r_col} + DIM_W'(1)) >= w;
        last_row  = ({1'b0, r_row} + DIM_W'(1)) >= h;
        frame_end = last_col && last_row;
        cvalid    = ~r_col[0];
        odd_row   = r_row[0];

        o_task.pixel        = i_pixel;
        o_task.luma_index   = r_luma_ptr;
        o_task.chroma_valid = cvalid;
        o_task.chroma_is_cb = cvalid && odd_row;
        o_task.chroma_index = !cvalid ? '0 : (odd_row ? r_cb_ptr : r_cr_ptr);
        o_task.frame_last   = frame_end;

        if (frame_end) begin
            n_col = '0;
            n_row = '0;
        end else if (last_col) begin
            n_col = '0;
            n_row = r_row + CNT_W'(1);
        end else begin
            n_col = r_col + CNT_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_luma_ptr <= '0;
            r_cr_ptr   <= '0;
            r_cb_ptr   <= CHROMA_IDX_W'(1);
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (frame_end) begin
                r_luma_ptr <= '0;
                r_cr_ptr   <= '0;
                r_cb_ptr   <= CHROMA_IDX_W'(1);
            end else begin
                r_luma_ptr <= r_luma_ptr + LUMA_IDX_W'(1);
                if (cvalid && odd_row) begin
                    r_cb_ptr <= r_cb_ptr + CHROMA_IDX_W'(2);
                end
                if (cvalid && !odd_row) begin
                    r_cr_ptr <= r_cr_ptr + CHROMA_IDX_W'(2);
                end
            end
        end
    end

endmodule

>>> sv/rtnv_queue.sv
// Two-entry queue of tagged pixels between front and back.
// Depends on rtnv_pkg.
module rtnv_queue import rtnv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    output logic  o_full,
    input  logic  i_pop,
    output t_task o_task,
    output logic  o_empty
);

    t_task      r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_task  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

>>> sv/rtnv_back.sv
// Back end: BT.601 color math on queued pixels, two-entry result buffer.
// Depends on rtnv_pkg.
module rtnv_back import rtnv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_task   i_task,
    output logic    o_q_pop,
    input  logic    i_pop,
    output t_result o_result,
    output logic    o_empty
);

    t_result     r_buf [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count;
    logic        take, give;
    logic [15:0] r16, g16, b16, y_sum, cr_sum, cb_sum;
    t_result     res;

    assign take     = !i_q_empty && (r_count != 2'd2);
    assign give     = i_pop && (r_count != 2'd0);
    assign o_q_pop  = take;
    assign o_empty  = r_count == 2'd0;
    assign o_result = r_buf[r_rd_ptr];

    always_comb begin
        r16    = {8'd0, i_task.pixel.red};
        g16    = {8'd0, i_task.pixel.green};
        b16    = {8'd0, i_task.pixel.blue};
        y_sum  = C_Y_R * r16 + C_Y_G * g16 + C_Y_B * b16 + C_RND;
        cr_sum = C_UV_M * r16 + C_BIAS - C_V_G * g16 - C_V_B * b16;
        cb_sum = C_UV_M * b16 + C_BIAS - C_U_R * r16 - C_U_G * g16;

        res.luma         = y_sum[15:8] + Y_OFS;
        res.luma_index   = i_task.luma_index;
        res.chroma_valid = i_task.chroma_valid;
        res.chroma       = !i_task.chroma_valid ? 8'd0
                         : (i_task.chroma_is_cb ? cb_sum[15:8] : cr_sum[15:8]);
        res.chroma_is_cb = i_task.chroma_is_cb;
        res.chroma_index = i_task.chroma_index;
        res.frame_last   = i_task.frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_buf[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (take) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (give) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, take} - {1'b0, give};
        end
    end

endmodule

>>> sv/rgb_to_nv21_converter.sv
// Top level of the RGB to NV21 converter: APB registers, front, queue, back.
// Depends on rtnv_pkg, rtnv_front, rtnv_queue, rtnv_back.

// Converts a stream of 8-bit RGB pixels, one per transaction and already in
// frame write order, into BT.601 studio-range NV21 data. Every pixel yields a
// result with its Y byte and luma-plane offset; even columns also carry one
// chroma byte for the interleaved VU plane (Cr from even rows at even
// offsets, Cb from odd rows at odd offsets). Throughput is one pixel per
// clock while full stays low and results are popped: the front end tags a
// pixel in the cycle it is accepted into the queue, and the back end takes
// it from the queue, computes the color math combinationally and registers
// the result into its result buffer, whence it shows on the result ports.
// Two-entry queues sit after the front and after the back, so input pushes
// continue while a result waits to be popped; full rises once both fill.
// frame_width and frame_height (APB offsets 0x0 and 0x4, 13 bits) are
// saturated to 1..4096 on use; write them only while the block is drained.
module rgb_to_nv21_converter import rtnv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // pixel input
    input  logic               push,
    output logic               full,
    input  t_pixel             i_pixel,
    // result output
    output logic               empty,
    input  logic               pop,
    output t_result            o_result,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_dims r_dims;
    t_task front_task, q_task;
    logic  in_accept, q_empty, q_pop;

    // ---- configuration registers ----
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.width  <= WIDTH_RESET;
            r_dims.height <= HEIGHT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_WIDTH:  r_dims.width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_dims.height <= pwdata[DIM_W-1:0];
                default:    r_dims        <= r_dims;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, r_dims.width};
            REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, r_dims.height};
            default:    prdata = '0;
        endcase
    end

    // ---- front: position tracking ----
    assign in_accept = push && !full;

    rtnv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dims   (r_dims),
        .i_accept (in_accept),
        .i_pixel  (i_pixel),
        .o_task   (front_task)
    );

    // ---- decoupling queue ----
    rtnv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_task  (front_task),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_task  (q_task),
        .o_empty (q_empty)
    );

    // ---- back: color math and result buffer ----
    rtnv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_task    (q_task),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_result  (o_result),
        .o_empty   (empty)
    );

`ifndef SYNTH
    // luma stays in studio range
    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.luma >= 8'd16) && (o_result.luma <= 8'd235))
        else $error("luma outside studio range");

    // Cb only with a chroma byte, and Cb at odd offsets
    a_cb_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.chroma_is_cb) |->
            (o_result.chroma_valid && o_result.chroma_index[0]))
        else $error("Cb tag or offset inconsistent");

    // Cr at even offsets
    a_cr_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.chroma_valid && !o_result.chroma_is_cb) |->
            !o_result.chroma_index[0])
        else $error("Cr at odd offset");

    // a pushed pixel never reaches the output in the very next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(empty) && $past(q_empty) && $past(i_rst_n)) |-> empty)
        else $error("result appeared without queued pixel");
`endif

endmodule
